### sv/ket_pkg.sv
package ket_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int WORDS           = 6;
  localparam int WORD_W          = 32;
  localparam int NODE_W          = 16;
  localparam int CHAN_W          = 8;
  localparam int KEY_W           = NODE_W + CHAN_W;
  localparam int ROW_W           = WORDS * WORD_W;
  localparam int CNT_OUT_W       = 5;

  typedef enum logic [1:0] {
    KIND_UPSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_FULL    = 2'd1,
    RES_MISSING = 2'd2
  } res_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      scan_start;
    logic      scan_next;
    logic      upd_write;
    logic      append;
    logic      clear;
    logic      shift_read;
    logic      shift_write;
    logic      shrink;
    logic      set_res;
    logic      take;
    res_code_t code;
    logic      emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  key_hit;
    logic  at_last;
    logic  empty;
    logic  full;
    logic  out_busy;
  } sts_t;

endpackage

### sv/keyed_entry_table_with_compaction.sv
// Keyed entry table: up to MAX_ENTRIES entries, each a 24-bit key
// ({node_id, channel}) and six 32-bit payload words, kept dense in slots
// 0 .. count-1 in insertion order.
// Request channel (req_valid / req_stall): kind selects upsert, lookup,
// remove or clear; a request is taken when req_valid is high and req_stall
// low. One request is worked on at a time; req_stall is high from the cycle
// after a request is taken until its result has been placed in the output
// register, so the next request may be taken while that result still waits.
// Result channel (res_valid / res_stall): exactly one result per request,
// carrying status, the looked-up payload (zero unless a lookup hit) and the
// entry count after the request. A stalled result holds; the block stops
// in its final step until the output register is free.
// A clear, or any request on an empty table, goes straight to the result;
// otherwise slots are searched in order until a hit or the last entry, one
// key and payload read per cycle through the single read port of the slot
// RAMs; a remove that hits then moves every later entry down one slot.
// The block returns to idle as the result is loaded and can take another request.
// Reset (rst, synchronous) empties the table and drops any pending result;
// slot RAMs need no clearing, since only slots below the count are read.
module keyed_entry_table_with_compaction #(
  parameter int MAX_ENTRIES = ket_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      kind,
  input  logic [ket_pkg::NODE_W-1:0]      node_id,
  input  logic [ket_pkg::CHAN_W-1:0]      channel,
  input  logic [ket_pkg::WORD_W-1:0]      alpha_word,
  input  logic [ket_pkg::WORD_W-1:0]      beta_word,
  input  logic [ket_pkg::WORD_W-1:0]      gamma_word,
  input  logic [ket_pkg::WORD_W-1:0]      wavelength_word,
  input  logic [ket_pkg::WORD_W-1:0]      range_low_word,
  input  logic [ket_pkg::WORD_W-1:0]      range_high_word,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [1:0]                      status,
  output logic [ket_pkg::WORD_W-1:0]      alpha_out,
  output logic [ket_pkg::WORD_W-1:0]      beta_out,
  output logic [ket_pkg::WORD_W-1:0]      gamma_out,
  output logic [ket_pkg::WORD_W-1:0]      wavelength_out,
  output logic [ket_pkg::WORD_W-1:0]      range_low_out,
  output logic [ket_pkg::WORD_W-1:0]      range_high_out,
  output logic [ket_pkg::CNT_OUT_W-1:0]   entry_count
);

  ket_pkg::cmd_t cmd;
  ket_pkg::sts_t sts;

  // Sequencer: search, update, append, compaction and result hand-off
  ket_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Request registers, slot RAMs, entry count and output register
  ket_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .node_id         (node_id),
    .channel         (channel),
    .alpha_word      (alpha_word),
    .beta_word       (beta_word),
    .gamma_word      (gamma_word),
    .wavelength_word (wavelength_word),
    .range_low_word  (range_low_word),
    .range_high_word (range_high_word),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .alpha_out       (alpha_out),
    .beta_out        (beta_out),
    .gamma_out       (gamma_out),
    .wavelength_out  (wavelength_out),
    .range_low_out   (range_low_out),
    .range_high_out  (range_high_out),
    .entry_count     (entry_count)
  );

`ifndef NO_ASSERTIONS
  // One request at a time: taking a request closes the request channel
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in progress");

  // A new result only follows work on a taken request
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without a request in progress");

  // Payload is shown only on success
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ket_pkg::RES_OK |->
      alpha_out == '0 && beta_out == '0 && gamma_out == '0 &&
      wavelength_out == '0 && range_low_out == '0 && range_high_out == '0)
    else $error("payload not zero on a failed request");

  // The count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (MAX_ENTRIES >= 32) ||
                  (entry_count <= ket_pkg::CNT_OUT_W'(MAX_ENTRIES)))
    else $error("entry count above table size");
`endif

endmodule

### sv/ket_ram.sv
module ket_ram #(
  parameter int WIDTH = ket_pkg::ROW_W,
  parameter int DEPTH = ket_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/ket_ctrl.sv
module ket_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ket_pkg::sts_t  sts,
  output ket_pkg::cmd_t  cmd
);

  ket_pkg::state_t state;
  ket_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ket_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic do_miss;
    do_miss    = 1'b0;
    cmd        = '0;
    cmd.code   = ket_pkg::RES_OK;
    state_next = state;
    req_stall  = (state != ket_pkg::ST_IDLE);

    case (state)
      ket_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ket_pkg::ST_START;
        end
      end
      ket_pkg::ST_START: begin
        if (sts.kind == ket_pkg::KIND_CLEAR) begin
          cmd.clear   = 1'b1;
          cmd.set_res = 1'b1;
          state_next  = ket_pkg::ST_DONE;
        end else if (sts.empty) begin
          do_miss = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ket_pkg::ST_SCAN;
        end
      end
      ket_pkg::ST_SCAN: begin
        if (sts.key_hit) begin
          cmd.set_res = 1'b1;
          state_next  = ket_pkg::ST_DONE;
          case (sts.kind)
            ket_pkg::KIND_UPSERT: cmd.upd_write = 1'b1;
            ket_pkg::KIND_LOOKUP: cmd.take = 1'b1;
            ket_pkg::KIND_REMOVE: state_next = ket_pkg::ST_SHIFT_RD;
            default:              cmd.take = 1'b0;
          endcase
        end else if (sts.at_last) begin
          do_miss = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ket_pkg::ST_SHIFT_RD: begin
        if (sts.at_last) begin
          cmd.shrink = 1'b1;
          state_next = ket_pkg::ST_DONE;
        end else begin
          cmd.shift_read = 1'b1;
          state_next     = ket_pkg::ST_SHIFT_WR;
        end
      end
      ket_pkg::ST_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        state_next      = ket_pkg::ST_SHIFT_RD;
      end
      ket_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ket_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ket_pkg::ST_IDLE;
      end
    endcase

    // No matching key: append, report full, or report missing
    if (do_miss) begin
      cmd.set_res = 1'b1;
      state_next  = ket_pkg::ST_DONE;
      if (sts.kind == ket_pkg::KIND_UPSERT) begin
        if (sts.full) begin
          cmd.code = ket_pkg::RES_FULL;
        end else begin
          cmd.append = 1'b1;
        end
      end else begin
        cmd.code = ket_pkg::RES_MISSING;
      end
    end
  end

endmodule

### sv/ket_dp.sv
module ket_dp #(
  parameter int MAX_ENTRIES = ket_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ket_pkg::cmd_t                   cmd,
  output ket_pkg::sts_t                   sts,
  input  logic [1:0]                      kind,
  input  logic [ket_pkg::NODE_W-1:0]      node_id,
  input  logic [ket_pkg::CHAN_W-1:0]      channel,
  input  logic [ket_pkg::WORD_W-1:0]      alpha_word,
  input  logic [ket_pkg::WORD_W-1:0]      beta_word,
  input  logic [ket_pkg::WORD_W-1:0]      gamma_word,
  input  logic [ket_pkg::WORD_W-1:0]      wavelength_word,
  input  logic [ket_pkg::WORD_W-1:0]      range_low_word,
  input  logic [ket_pkg::WORD_W-1:0]      range_high_word,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [1:0]                      status,
  output logic [ket_pkg::WORD_W-1:0]      alpha_out,
  output logic [ket_pkg::WORD_W-1:0]      beta_out,
  output logic [ket_pkg::WORD_W-1:0]      gamma_out,
  output logic [ket_pkg::WORD_W-1:0]      wavelength_out,
  output logic [ket_pkg::WORD_W-1:0]      range_low_out,
  output logic [ket_pkg::WORD_W-1:0]      range_high_out,
  output logic [ket_pkg::CNT_OUT_W-1:0]   entry_count
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = ket_pkg::WORD_W;

  ket_pkg::kind_t            req_kind;
  logic [ket_pkg::KEY_W-1:0] req_key;
  logic [ket_pkg::ROW_W-1:0] req_row;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  logic [CW-1:0]             idx_inc;
  ket_pkg::res_code_t        res_code;
  logic                      res_take;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ket_pkg::KEY_W-1:0] wr_key;
  logic [ket_pkg::ROW_W-1:0] wr_row;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [ket_pkg::KEY_W-1:0] key_rd;
  logic [ket_pkg::ROW_W-1:0] row_rd;

  assign idx_inc = idx + CW'(1);

  always_comb begin
    wr_en   = cmd.upd_write | cmd.append | cmd.shift_write;
    wr_addr = cmd.append ? count[AW-1:0] : idx[AW-1:0];
    wr_key  = cmd.shift_write ? key_rd : req_key;
    wr_row  = cmd.shift_write ? row_rd : req_row;
    rd_en   = cmd.scan_start | cmd.scan_next | cmd.shift_read;
    rd_addr = cmd.scan_start ? '0 : idx_inc[AW-1:0];
  end

  ket_ram #(.WIDTH(ket_pkg::KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  ket_ram #(.WIDTH(ket_pkg::ROW_W), .DEPTH(MAX_ENTRIES)) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (row_rd)
  );

  always_comb begin
    sts.kind     = req_kind;
    sts.key_hit  = (key_rd == req_key);
    sts.at_last  = (idx_inc >= count);
    sts.empty    = (count == '0);
    sts.full     = (count == CW'(MAX_ENTRIES));
    sts.out_busy = res_valid & res_stall;
  end

  // Request capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind <= ket_pkg::kind_t'(kind);
      req_key  <= {node_id, channel};
      req_row  <= {range_high_word, range_low_word, wavelength_word,
                   gamma_word, beta_word, alpha_word};
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_next | cmd.shift_write) begin
      idx <= idx_inc;
    end
    if (cmd.set_res) begin
      res_code <= cmd.code;
      res_take <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end else if (cmd.shrink) begin
      count <= count - CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= res_code;
      alpha_out      <= res_take ? row_rd[0*WW +: WW] : '0;
      beta_out       <= res_take ? row_rd[1*WW +: WW] : '0;
      gamma_out      <= res_take ? row_rd[2*WW +: WW] : '0;
      wavelength_out <= res_take ? row_rd[3*WW +: WW] : '0;
      range_low_out  <= res_take ? row_rd[4*WW +: WW] : '0;
      range_high_out <= res_take ? row_rd[5*WW +: WW] : '0;
      entry_count    <= ket_pkg::CNT_OUT_W'(count);
    end
  end

endmodule
